/* rtl/lmfc_pkg.sv */
`default_nettype none

package lmfc_pkg;

	// Largest response a frame may carry, in bytes.
	localparam int MAX_FRAME_BYTES = 8;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 4;
	localparam int PAY_W    = MAX_FRAME_BYTES * BYTE_W;
	localparam int IDX_W    = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam int ERR_W    = 10;
	localparam int TMO_W    = 12;
	localparam int MAX_RES  = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);

	localparam logic [BYTE_W-1:0] SLEEP_PID  = 8'h3C;
	localparam logic [BYTE_W-1:0] WAKE_PID   = 8'h00;
	localparam logic [LEN_W-1:0]  WAKE_LEN   = 4'd2;
	localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_FRAME_BYTES);
	// Sleep frame data: first byte zero, the rest all ones.
	localparam logic [PAY_W-1:0]  SLEEP_DATA = {{(PAY_W - BYTE_W){1'b1}}, {BYTE_W{1'b0}}};

	// Receive timeout (10n+45)*14/10 reduces exactly to 14n+63.
	localparam logic [TMO_W-1:0] TMO_SLOPE  = TMO_W'(14);
	localparam logic [TMO_W-1:0] TMO_OFFSET = TMO_W'(63);

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_DEINIT = 3'd1,
		OP_HEADER = 3'd2,
		OP_IRQ    = 3'd3,
		OP_STATUS = 3'd4,
		OP_SLEEP  = 3'd5,
		OP_WAKE   = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		ST_UNINIT = 4'd0,
		ST_OPER   = 4'd1,
		ST_SLEEP  = 4'd2,
		ST_TXBUSY = 4'd3,
		ST_TXOK   = 4'd4,
		ST_TXERR  = 4'd5,
		ST_RXBUSY = 4'd6,
		ST_RXOK   = 4'd7,
		ST_RXERR  = 4'd8
	} status_t;

	// Everything one operation reports, held in the output register.
	typedef struct packed {
		logic [RES_IDX_W-1:0]          last_idx;
		logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
		logic                          byte_valid;
		status_t                       status;
		logic [PAY_W-1:0]              payload;
		logic                          resync;
		logic                          ok;
	} res_t;

endpackage

`default_nettype wire

/* rtl/lin_master_frame_controller_core.sv */
`default_nettype none

// Channel   Handshake               Transaction content
// in        in_valid / in_ready     op, pid, frame_length, master_response,
//                                   enhanced_checksum, tx_payload, status flags,
//                                   error_flags, rx_byte
// out       out_valid / out_ready   bus_byte_valid, bus_byte, channel_status,
//                                   rx_payload, resync_request, request_ok, last_item
//
// An input transaction lands in the input register; once the output register is free,
// the whole operation is evaluated and its results are loaded into the output register.
// A send_header, go_to_sleep or wake_up that sends a header yields three or four
// results, one per cycle from the output register while out_ready is high; every other
// operation yields one. Single-result operations go at one transaction per cycle while
// out_ready is high; after a header the next one waits until its last result is taken.
// Reset clears channel status, counters and both pipeline valids; no clearing pass is needed.
// A stalled output holds the output register, then the input register, then in_ready.

module lin_master_frame_controller_core (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        in_valid,
	output logic                                             in_ready,
	input  wire logic [2:0]                                  op,
	input  wire logic [lmfc_pkg::BYTE_W-1:0]                 pid,
	input  wire logic [lmfc_pkg::LEN_W-1:0]                  frame_length,
	input  wire logic                                        master_response,
	input  wire logic                                        enhanced_checksum,
	input  wire logic [lmfc_pkg::PAY_W-1:0]                  tx_payload,
	input  wire logic                                        flag_tx_ready,
	input  wire logic                                        flag_rx_ready,
	input  wire logic                                        flag_frame_complete,
	input  wire logic [lmfc_pkg::ERR_W-1:0]                  error_flags,
	input  wire logic [lmfc_pkg::BYTE_W-1:0]                 rx_byte,
	output logic                                             out_valid,
	input  wire logic                                        out_ready,
	output logic                                             bus_byte_valid,
	output logic [lmfc_pkg::BYTE_W-1:0]                      bus_byte,
	output logic [3:0]                                       channel_status,
	output logic [lmfc_pkg::PAY_W-1:0]                       rx_payload,
	output logic                                             resync_request,
	output logic                                             request_ok,
	output logic                                             last_item
);
	import lmfc_pkg::*;

	// Input register.
	logic               valid_s1;
	op_t                op_s1;
	logic [BYTE_W-1:0]  pid_s1;
	logic [LEN_W-1:0]   len_s1;
	logic               master_s1;
	logic               enh_s1;
	logic [PAY_W-1:0]   tx_payload_s1;
	logic               txr_s1;
	logic               rxr_s1;
	logic               frc_s1;
	logic               err_s1;
	logic [BYTE_W-1:0]  rx_byte_s1;

	// Output register and its result counter.
	logic               valid_s2;
	res_t               res_s2;
	logic [RES_IDX_W-1:0] res_idx_q;

	// Channel state.
	status_t            status_q;
	logic               sleep_q;
	logic [PAY_W-1:0]   tx_store_q;
	logic [LEN_W-1:0]   tx_left_q;
	logic [IDX_W-1:0]   tx_idx_q;
	logic [PAY_W-1:0]   rx_store_q;
	logic [LEN_W-1:0]   rx_left_q;
	logic [IDX_W-1:0]   rx_idx_q;

	// Next state and result of the operation in the input register.
	status_t            st_n;
	logic               sleep_n;
	logic [PAY_W-1:0]   tx_store_n;
	logic [LEN_W-1:0]   tx_left_n;
	logic [IDX_W-1:0]   tx_idx_n;
	logic [PAY_W-1:0]   rx_store_n;
	logic [LEN_W-1:0]   rx_left_n;
	logic [IDX_W-1:0]   rx_idx_n;
	res_t               res_n;

	// Header request, shared by send_header, go_to_sleep and wake_up.
	logic               h_go;
	logic               h_wake;
	logic [BYTE_W-1:0]  h_pid;
	logic [LEN_W-1:0]   h_len;
	logic               h_master;
	logic               h_enh;
	logic [PAY_W-1:0]   h_pay;
	logic               h_busy;
	status_t            h_st0;
	logic [LEN_W-1:0]   h_n;
	logic [TMO_W-1:0]   h_tmo;
	logic [BYTE_W-1:0]  h_ctrl;

	logic               out_last;
	logic               out_acc;
	logic               s2_free;
	logic               fire_s1;

	assign out_last = (res_idx_q == res_s2.last_idx);
	assign out_acc  = valid_s2 && out_ready;
	assign s2_free  = !valid_s2 || (out_ready && out_last);
	assign fire_s1  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	assign out_valid      = valid_s2;
	assign bus_byte_valid = res_s2.byte_valid;
	assign bus_byte       = res_s2.bytes[res_idx_q];
	assign channel_status = res_s2.status;
	assign rx_payload     = res_s2.payload;
	assign resync_request = res_s2.resync;
	assign request_ok     = res_s2.ok;
	assign last_item      = out_last;

	assign h_busy = (status_q == ST_TXBUSY) || (status_q == ST_TXERR) ||
	                (status_q == ST_RXBUSY) || (status_q == ST_RXERR);
	assign h_st0  = h_busy ? ST_OPER : status_q;

	always_comb begin
		st_n       = status_q;
		sleep_n    = sleep_q;
		tx_store_n = tx_store_q;
		tx_left_n  = tx_left_q;
		tx_idx_n   = tx_idx_q;
		rx_store_n = rx_store_q;
		rx_left_n  = rx_left_q;
		rx_idx_n   = rx_idx_q;
		res_n      = '0;
		res_n.status = status_q;
		h_go     = 1'b0;
		h_wake   = 1'b0;
		h_pid    = pid_s1;
		h_len    = len_s1;
		h_master = master_s1;
		h_enh    = enh_s1;
		h_pay    = tx_payload_s1;

		unique case (op_s1)
			OP_INIT: begin
				st_n         = ST_OPER;
				res_n.status = ST_OPER;
				res_n.ok     = 1'b1;
			end
			OP_DEINIT: begin
				st_n         = ST_UNINIT;
				res_n.status = ST_UNINIT;
				res_n.ok     = 1'b1;
			end
			OP_HEADER: begin
				h_go = 1'b1;
			end
			OP_IRQ: begin
				if (status_q == ST_TXBUSY) begin
					if (tx_left_q != '0 && txr_s1) begin
						res_n.bytes[0]   = tx_store_q[tx_idx_q*BYTE_W +: BYTE_W];
						res_n.byte_valid = 1'b1;
						tx_idx_n         = tx_idx_q + 1'b1;
						tx_left_n        = tx_left_q - 1'b1;
					end else if (sleep_q) begin
						st_n    = ST_SLEEP;
						sleep_n = 1'b0;
					end else begin
						st_n = frc_s1 ? ST_TXOK : ST_TXERR;
					end
				end else if (status_q == ST_RXBUSY) begin
					if (rx_left_q != '0 && rxr_s1) begin
						rx_store_n[rx_idx_q*BYTE_W +: BYTE_W] = rx_byte_s1;
						rx_idx_n  = rx_idx_q + 1'b1;
						rx_left_n = rx_left_q - 1'b1;
					end else if (rx_left_q == '0 && frc_s1) begin
						st_n = ST_RXOK;
					end
				end
				// Any error flag turns a still-busy channel into its error state.
				if (err_s1) begin
					if (st_n == ST_RXBUSY) begin
						st_n = ST_RXERR;
					end else if (st_n == ST_TXBUSY) begin
						st_n = ST_TXERR;
					end
				end
				res_n.status = st_n;
				res_n.ok     = 1'b1;
			end
			OP_STATUS: begin
				// The result reports the status before it is acknowledged.
				if (status_q != ST_UNINIT) begin
					res_n.ok = 1'b1;
					if (status_q == ST_RXOK || status_q == ST_RXERR) begin
						res_n.payload = rx_store_q;
						res_n.resync  = (status_q == ST_RXERR);
						st_n          = ST_OPER;
					end else if (status_q == ST_TXOK || status_q == ST_TXERR) begin
						res_n.resync = (status_q == ST_TXERR);
						st_n         = ST_OPER;
					end
				end
			end
			OP_SLEEP: begin
				if (status_q == ST_UNINIT || status_q == ST_SLEEP) begin
					res_n.ok = 1'b0;
				end else if (sleep_q) begin
					res_n.ok = 1'b1;
				end else begin
					sleep_n  = 1'b1;
					h_go     = 1'b1;
					h_pid    = SLEEP_PID;
					h_len    = MAX_LEN;
					h_master = 1'b1;
					h_enh    = 1'b0;
					h_pay    = SLEEP_DATA;
				end
			end
			OP_WAKE: begin
				if (status_q == ST_SLEEP) begin
					h_go     = 1'b1;
					h_wake   = 1'b1;
					h_pid    = WAKE_PID;
					h_len    = WAKE_LEN;
					h_master = 1'b0;
					h_enh    = 1'b0;
				end
			end
			default: begin
				res_n.ok = 1'b0;
			end
		endcase

		// Header byte arithmetic. The length saturates to the largest frame, and the
		// timeout only goes into the control byte and timeout byte of a receive frame.
		h_n    = (h_len > MAX_LEN) ? MAX_LEN : h_len;
		h_tmo  = TMO_SLOPE * TMO_W'(h_n) + TMO_OFFSET;
		h_ctrl = {h_enh, 1'b1, 1'b0, h_master,
		          h_master ? 4'd0 : h_tmo[TMO_W-1:BYTE_W]};

		if (h_go) begin
			res_n.resync = h_busy;
			if (h_st0 == ST_UNINIT) begin
				// Header on an uninitialized channel is refused without bus traffic.
				st_n         = h_st0;
				res_n.status = h_st0;
				res_n.ok     = 1'b0;
			end else begin
				res_n.ok         = 1'b1;
				res_n.byte_valid = 1'b1;
				res_n.bytes[0]   = h_pid;
				res_n.bytes[1]   = BYTE_W'(h_n);
				res_n.bytes[2]   = h_ctrl;
				if (h_master) begin
					st_n         = ST_TXBUSY;
					tx_store_n   = h_pay;
					tx_left_n    = h_n;
					tx_idx_n     = '0;
					res_n.last_idx = RES_IDX_W'(2);
				end else begin
					st_n           = ST_RXBUSY;
					rx_store_n     = '0;
					rx_left_n      = h_n;
					rx_idx_n       = '0;
					res_n.bytes[3] = h_tmo[BYTE_W-1:0];
					res_n.last_idx = RES_IDX_W'(3);
				end
				res_n.status = st_n;
				// A wake-up header leaves the channel operational at once.
				if (h_wake) begin
					st_n         = ST_OPER;
					res_n.status = ST_OPER;
				end
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			res_idx_q <= '0;
			status_q  <= ST_UNINIT;
			sleep_q   <= 1'b0;
			tx_left_q <= '0;
			tx_idx_q  <= '0;
			rx_left_q <= '0;
			rx_idx_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_acc && out_last) begin
				valid_s2 <= 1'b0;
			end
			if (out_acc) begin
				res_idx_q <= out_last ? '0 : res_idx_q + 1'b1;
			end
			if (fire_s1) begin
				status_q  <= st_n;
				sleep_q   <= sleep_n;
				tx_left_q <= tx_left_n;
				tx_idx_q  <= tx_idx_n;
				rx_left_q <= rx_left_n;
				rx_idx_q  <= rx_idx_n;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1         <= op_t'(op);
			pid_s1        <= pid;
			len_s1        <= frame_length;
			master_s1     <= master_response;
			enh_s1        <= enhanced_checksum;
			tx_payload_s1 <= tx_payload;
			txr_s1        <= flag_tx_ready;
			rxr_s1        <= flag_rx_ready;
			frc_s1        <= flag_frame_complete;
			err_s1        <= |error_flags;
			rx_byte_s1    <= rx_byte;
		end
		if (fire_s1) begin
			res_s2     <= res_n;
			tx_store_q <= tx_store_n;
			rx_store_q <= rx_store_n;
		end
	end

	// Results of one header transaction share status and resync.
	a_header_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_item |=>
			out_valid && channel_status == $past(channel_status) &&
			resync_request == $past(resync_request))
		else $error("header results disagree on status or resync");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bus_byte_valid |-> bus_byte == '0)
		else $error("bus byte nonzero without a write");

	a_payload_rx_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_payload != '0 |->
			channel_status == ST_RXOK || channel_status == ST_RXERR)
		else $error("receive payload outside a receive status report");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !request_ok |-> !bus_byte_valid && last_item)
		else $error("rejected transaction produced bus traffic");

	a_input_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1)
		else $error("input register dropped a stalled transaction");

endmodule

`default_nettype wire

/* sim/lin_master_frame_controller_core_tb.sv */
`timescale 1ns / 1ps

// Testbench for one LIN master channel. Operation transactions go in on the
// in channel; every header byte, status report or acknowledge comes back as a
// result transaction on the out channel. A scoreboard keeps its own copy of
// the channel state, predicts the results of every accepted input transaction
// and checks each accepted output transaction against the oldest prediction.
module lin_master_frame_controller_core_tb;
	import lmfc_pkg::*;

	// One input transaction, one field per data input port of the block.
	typedef struct {
		logic [2:0]  op;
		logic [7:0]  pid;
		logic [3:0]  len;
		logic        master;
		logic        enh;
		logic [63:0] payload;
		logic        txr;
		logic        rxr;
		logic        frc;
		logic [9:0]  errs;
		logic [7:0]  rxb;
	} lin_req_t;

	// One output transaction.
	typedef struct {
		logic        bvalid;
		logic [7:0]  bbyte;
		logic [3:0]  status;
		logic [63:0] rxpay;
		logic        resync;
		logic        ok;
		logic        last;
	} lin_rsp_t;

	// The scoreboard mirrors the channel: status, the pending sleep order and
	// both response stores with their counters. Every accepted input
	// transaction appends its predicted results to frames_due.
	class lin_channel_sb;
		status_t     status_now;
		bit          sleep_pending;
		bit [7:0]    tx_bytes[8];
		bit [7:0]    rx_bytes[8];
		int unsigned tx_left;
		int unsigned rx_left;
		bit [2:0]    tx_idx;
		bit [2:0]    rx_idx;
		lin_rsp_t    frames_due[$];
		int unsigned mismatches;

		function new();
			status_now = ST_UNINIT;
			sleep_pending = 1'b0;
			tx_left = 0;
			rx_left = 0;
			tx_idx = 0;
			rx_idx = 0;
			mismatches = 0;
			foreach (tx_bytes[i]) tx_bytes[i] = 8'h00;
			foreach (rx_bytes[i]) rx_bytes[i] = 8'h00;
		endfunction

		function void push(bit v, bit [7:0] b, status_t st, bit [63:0] pay, bit rs, bit ok);
			lin_rsp_t r;
			r.bvalid = v;
			r.bbyte = v ? b : 8'h00;
			r.status = st;
			r.rxpay = pay;
			r.resync = rs;
			r.ok = ok;
			r.last = 1'b0;
			frames_due.push_back(r);
		endfunction

		// A header leaves any busy or error state through a resync first.
		function void emit_header(bit [7:0] p, bit [3:0] len, bit master, bit enh,
				bit [63:0] data);
			bit          rs;
			int unsigned n;
			bit [11:0]   tmo;
			bit [7:0]    ctrl;
			rs = 1'b0;
			if (status_now inside {ST_TXBUSY, ST_TXERR, ST_RXBUSY, ST_RXERR}) begin
				status_now = ST_OPER;
				rs = 1'b1;
			end
			if (status_now == ST_UNINIT) begin
				push(1'b0, 8'h00, status_now, 64'd0, rs, 1'b0);
				return;
			end
			n = (len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : len;
			tmo = 12'(((10 * n + 45) * 14) / 10);
			ctrl = {enh, 1'b1, 6'd0};
			if (master) begin
				ctrl[4] = 1'b1;
				status_now = ST_TXBUSY;
				for (int i = 0; i < n; i++)
					tx_bytes[i] = data[8*i +: 8];
				tx_left = n;
				tx_idx = 0;
			end else begin
				ctrl[3:0] = tmo[11:8];
				status_now = ST_RXBUSY;
				foreach (rx_bytes[i]) rx_bytes[i] = 8'h00;
				rx_left = n;
				rx_idx = 0;
			end
			push(1'b1, p, status_now, 64'd0, rs, 1'b1);
			push(1'b1, 8'(n), status_now, 64'd0, rs, 1'b1);
			push(1'b1, ctrl, status_now, 64'd0, rs, 1'b1);
			if (!master)
				push(1'b1, tmo[7:0], status_now, 64'd0, rs, 1'b1);
		endfunction

		function void irq_step(lin_req_t it);
			bit       sent;
			bit [7:0] tx_out;
			sent = 1'b0;
			tx_out = 8'h00;
			if (status_now == ST_TXBUSY) begin
				if (tx_left > 0 && it.txr) begin
					tx_out = tx_bytes[tx_idx];
					tx_idx = tx_idx + 3'd1;
					tx_left--;
					sent = 1'b1;
				end else if (sleep_pending) begin
					status_now = ST_SLEEP;
					sleep_pending = 1'b0;
				end else begin
					status_now = it.frc ? ST_TXOK : ST_TXERR;
				end
			end else if (status_now == ST_RXBUSY) begin
				if (rx_left > 0 && it.rxr) begin
					rx_bytes[rx_idx] = it.rxb;
					rx_idx = rx_idx + 3'd1;
					rx_left--;
				end else if (rx_left == 0 && it.frc) begin
					status_now = ST_RXOK;
				end
			end
			if (|it.errs) begin
				if (status_now == ST_RXBUSY)
					status_now = ST_RXERR;
				else if (status_now == ST_TXBUSY)
					status_now = ST_TXERR;
			end
			push(sent, tx_out, status_now, 64'd0, 1'b0, 1'b1);
		endfunction

		// The report carries the status before acknowledgement.
		function void report_status();
			status_t   rep;
			bit [63:0] pay;
			bit        rs;
			rep = status_now;
			pay = 64'd0;
			rs = 1'b0;
			if (rep == ST_UNINIT) begin
				push(1'b0, 8'h00, rep, 64'd0, 1'b0, 1'b0);
				return;
			end
			if (rep == ST_RXOK || rep == ST_RXERR) begin
				for (int i = 0; i < 8; i++)
					pay[8*i +: 8] = rx_bytes[i];
				rs = (rep == ST_RXERR);
				status_now = ST_OPER;
			end else if (rep == ST_TXOK || rep == ST_TXERR) begin
				rs = (rep == ST_TXERR);
				status_now = ST_OPER;
			end
			push(1'b0, 8'h00, rep, pay, rs, 1'b1);
		endfunction

		function void note_input(lin_req_t it);
			int       first;
			lin_rsp_t r;
			first = frames_due.size();
			case (it.op)
				OP_INIT: begin
					status_now = ST_OPER;
					push(1'b0, 8'h00, status_now, 64'd0, 1'b0, 1'b1);
				end
				OP_DEINIT: begin
					status_now = ST_UNINIT;
					push(1'b0, 8'h00, status_now, 64'd0, 1'b0, 1'b1);
				end
				OP_HEADER: emit_header(it.pid, it.len, it.master, it.enh, it.payload);
				OP_IRQ: irq_step(it);
				OP_STATUS: report_status();
				OP_SLEEP: begin
					if (status_now == ST_UNINIT || status_now == ST_SLEEP) begin
						push(1'b0, 8'h00, status_now, 64'd0, 1'b0, 1'b0);
					end else if (sleep_pending) begin
						push(1'b0, 8'h00, status_now, 64'd0, 1'b0, 1'b1);
					end else begin
						sleep_pending = 1'b1;
						emit_header(SLEEP_PID, MAX_LEN, 1'b1, 1'b0, SLEEP_DATA);
					end
				end
				OP_WAKE: begin
					if (status_now != ST_SLEEP) begin
						push(1'b0, 8'h00, status_now, 64'd0, 1'b0, 1'b0);
					end else begin
						// The wake header goes out, but the channel is operational
						// at once, so all of its results report operational.
						emit_header(WAKE_PID, WAKE_LEN, 1'b0, 1'b0, 64'hFFFF);
						status_now = ST_OPER;
						for (int i = first; i < frames_due.size(); i++) begin
							r = frames_due[i];
							r.status = ST_OPER;
							frames_due[i] = r;
						end
					end
				end
				default: push(1'b0, 8'h00, status_now, 64'd0, 1'b0, 1'b0);
			endcase
			r = frames_due[frames_due.size() - 1];
			r.last = 1'b1;
			frames_due[frames_due.size() - 1] = r;
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(lin_rsp_t got);
			lin_rsp_t want;
			if (frames_due.size() == 0) begin
				$error("result transaction with no prediction waiting");
				mismatches++;
				return;
			end
			want = frames_due.pop_front();
			cmp_field("bus_byte_valid", want.bvalid, got.bvalid);
			cmp_field("bus_byte", want.bbyte, got.bbyte);
			cmp_field("channel_status", want.status, got.status);
			cmp_field("rx_payload", want.rxpay, got.rxpay);
			cmp_field("resync_request", want.resync, got.resync);
			cmp_field("request_ok", want.ok, got.ok);
			cmp_field("last_item", want.last, got.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  op;
	logic [7:0]  pid;
	logic [3:0]  frame_length;
	logic        master_response;
	logic        enhanced_checksum;
	logic [63:0] tx_payload;
	logic        flag_tx_ready;
	logic        flag_rx_ready;
	logic        flag_frame_complete;
	logic [9:0]  error_flags;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        bus_byte_valid;
	logic [7:0]  bus_byte;
	logic [3:0]  channel_status;
	logic [63:0] rx_payload;
	logic        resync_request;
	logic        request_ok;
	logic        last_item;

	lin_channel_sb sb;
	int unsigned   burst_left = 0;
	int unsigned   items_sent = 0;
	int unsigned   stall_mode = 0;
	int unsigned   stall_span = 0;

	lin_master_frame_controller_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: out_ready follows a randomly chosen pattern: always ready, coin
	// flips, a periodic stall or long stretches of mostly stalled.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(8, 80);
		end
		stall_span--;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (stall_span % 4 != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Every output transaction is checked at the edge that accepts it.
	always @(posedge clk) begin : result_monitor
		lin_rsp_t got;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			got.bvalid = bus_byte_valid;
			got.bbyte = bus_byte;
			got.status = channel_status;
			got.rxpay = rx_payload;
			got.resync = resync_request;
			got.ok = request_ok;
			got.last = last_item;
			sb.check_result(got);
		end
	end

	// Sender: transactions go out in bursts of random length. Between bursts
	// in_valid drops for a random gap, which may be zero, so the gaps land on
	// every phase of a multi-byte header.
	task automatic send_item(input lin_req_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= it.op;
		pid <= it.pid;
		frame_length <= it.len;
		master_response <= it.master;
		enhanced_checksum <= it.enh;
		tx_payload <= it.payload;
		flag_tx_ready <= it.txr;
		flag_rx_ready <= it.rxr;
		flag_frame_complete <= it.frc;
		error_flags <= it.errs;
		rx_byte <= it.rxb;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_input(it);
		items_sent++;
	endtask

	// Fully random transaction; the builders below override what matters.
	function automatic lin_req_t noise_req();
		lin_req_t it;
		it.op = 3'($urandom_range(0, 7));
		it.pid = 8'($urandom);
		it.len = 4'($urandom_range(0, 15));
		it.master = 1'($urandom_range(0, 1));
		it.enh = 1'($urandom_range(0, 1));
		it.payload = {$urandom, $urandom};
		it.txr = 1'($urandom_range(0, 1));
		it.rxr = 1'($urandom_range(0, 1));
		it.frc = 1'($urandom_range(0, 1));
		it.errs = 10'($urandom_range(0, 1023));
		it.rxb = 8'($urandom);
		return it;
	endfunction

	task automatic do_simple(input logic [2:0] code);
		lin_req_t it;
		it = noise_req();
		it.op = code;
		send_item(it);
	endtask

	task automatic do_header(input logic [7:0] p, input logic [3:0] len, input logic master,
			input logic enh, input logic [63:0] data);
		lin_req_t it;
		it = noise_req();
		it.op = OP_HEADER;
		it.pid = p;
		it.len = len;
		it.master = master;
		it.enh = enh;
		it.payload = data;
		send_item(it);
	endtask

	task automatic do_irq(input logic txr, input logic rxr, input logic frc,
			input logic [9:0] errs, input logic [7:0] rxb);
		lin_req_t it;
		it = noise_req();
		it.op = OP_IRQ;
		it.txr = txr;
		it.rxr = rxr;
		it.frc = frc;
		it.errs = errs;
		it.rxb = rxb;
		send_item(it);
	endtask

	// Error flags are rare in well-formed frames: a single flag or a random mix.
	function automatic logic [9:0] pick_errs();
		if ($urandom_range(0, 14) != 0)
			return 10'd0;
		if ($urandom_range(0, 1) != 0)
			return 10'd1 << $urandom_range(0, 9);
		return 10'($urandom_range(1, 1023));
	endfunction

	// Mostly legal lengths, now and then one that must saturate.
	function automatic logic [3:0] pick_len();
		if ($urandom_range(0, 9) == 0)
			return 4'($urandom_range(9, 15));
		return 4'($urandom_range(0, 8));
	endfunction

	task automatic tx_frame();
		logic [3:0]  len;
		int unsigned n;
		len = pick_len();
		n = (len > 8) ? 8 : len;
		do_header(8'($urandom), len, 1'b1, 1'($urandom_range(0, 1)), {$urandom, $urandom});
		repeat (n)
			do_irq($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), 1'b0, pick_errs(),
				8'($urandom));
		do_irq(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0,
			pick_errs(), 8'($urandom));
		if ($urandom_range(0, 4) != 0)
			do_simple(OP_STATUS);
	endtask

	task automatic rx_frame();
		logic [3:0]  len;
		int unsigned n;
		len = pick_len();
		n = (len > 8) ? 8 : len;
		do_header(8'($urandom), len, 1'b0, 1'($urandom_range(0, 1)), {$urandom, $urandom});
		repeat (n)
			do_irq(1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
				$urandom_range(0, 7) == 0, pick_errs(), 8'($urandom));
		do_irq(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(0, 5) != 0,
			pick_errs(), 8'($urandom));
		if ($urandom_range(0, 4) != 0)
			do_simple(OP_STATUS);
	endtask

	// Sleep frame: eight bytes, then the end event that puts the channel to
	// sleep. Half the time it is woken here; otherwise a later header wakes it.
	task automatic sleep_cycle();
		do_simple(OP_SLEEP);
		if ($urandom_range(0, 3) == 0)
			do_simple(OP_SLEEP);
		repeat (9)
			do_irq($urandom_range(0, 11) != 0, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), pick_errs(), 8'($urandom));
		do_irq(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_errs(),
			8'($urandom));
		if ($urandom_range(0, 1) != 0) begin
			do_simple(OP_WAKE);
			if ($urandom_range(0, 1) != 0)
				do_irq(1'b1, 1'b1, 1'b1, 10'd0, 8'($urandom));
		end
	endtask

	task automatic directed_part();
		// Status, header, sleep, wake and an unknown op are all rejected while uninitialized.
		do_simple(OP_STATUS);
		do_header(8'h55, 4'd3, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF);
		do_simple(OP_SLEEP);
		do_simple(OP_WAKE);
		do_simple(3'd7);
		do_irq(1'b1, 1'b1, 1'b1, 10'd0, 8'h00);
		do_simple(OP_INIT);
		// A zero-length transmit frame ends at once with frame complete.
		do_header(8'hFF, 4'd0, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		do_irq(1'b1, 1'b0, 1'b1, 10'd0, 8'h00);
		do_simple(OP_STATUS);
		// Saturated receive length, two bytes in, the second with an error flag that gives a receive error.
		do_header(8'h00, 4'd15, 1'b0, 1'b0, 64'd0);
		do_irq(1'b0, 1'b1, 1'b0, 10'd0, 8'hA5);
		do_irq(1'b0, 1'b1, 1'b0, 10'h200, 8'h5A);
		do_simple(OP_STATUS);
		// One-byte receive frame that completes cleanly.
		do_header(8'h80, 4'd1, 1'b0, 1'b1, 64'd0);
		do_irq(1'b0, 1'b1, 1'b0, 10'd0, 8'hFF);
		do_irq(1'b0, 1'b0, 1'b1, 10'd0, 8'h00);
		do_simple(OP_STATUS);
		// A header on a busy channel resyncs; an error flag aborts the send.
		do_header(8'hC1, 4'd8, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		do_header(8'h42, 4'd2, 1'b1, 1'b1, 64'h0000_0000_0000_A55A);
		do_irq(1'b1, 1'b0, 1'b0, 10'h3FF, 8'h00);
		// Sleep from the error state, a repeated order, the end of the sleep
		// frame, a rejected order in sleep, then the wake header.
		do_simple(OP_SLEEP);
		do_simple(OP_SLEEP);
		do_irq(1'b0, 1'b0, 1'b0, 10'd0, 8'h00);
		do_simple(OP_SLEEP);
		do_simple(OP_WAKE);
		do_irq(1'b1, 1'b1, 1'b1, 10'd0, 8'h33);
		do_simple(OP_DEINIT);
	endtask

	task automatic random_part(input int unsigned target);
		int unsigned kind;
		int unsigned start;
		start = items_sent;
		while (items_sent - start < target) begin
			kind = $urandom_range(0, 99);
			if (sb.status_now == ST_UNINIT && kind < 85)
				do_simple(OP_INIT);
			if (kind < 30)
				tx_frame();
			else if (kind < 60)
				rx_frame();
			else if (kind < 72)
				sleep_cycle();
			else if (kind < 87)
				repeat ($urandom_range(1, 4)) send_item(noise_req());
			else if (kind < 92)
				do_simple(($urandom_range(0, 2) == 0) ? OP_DEINIT : OP_INIT);
			else
				do_simple(OP_STATUS);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_INIT;
		pid = 8'h00;
		frame_length = 4'd0;
		master_response = 1'b0;
		enhanced_checksum = 1'b0;
		tx_payload = 64'd0;
		flag_tx_ready = 1'b0;
		flag_rx_ready = 1'b0;
		flag_frame_complete = 1'b0;
		error_flags = 10'd0;
		rx_byte = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_part();
		random_part(430);
		in_valid <= 1'b0;
		// Drain, then give the output register time to show anything stray.
		while (sb.frames_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: a run that hangs ends with an error.
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
